// ----- rtl/sdt_pkg.sv -----
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared constants, codes and controller/datapath interface types for the
// sequence duplicate suppression table.
// ----------------------------------------------------------------------------
package sdt_pkg;

  // Table size default and field widths
  localparam int TABLE_DEPTH_DEF = 20;
  localparam int CMD_W   = 2;
  localparam int NODE_W  = 16;
  localparam int EP_W    = 8;
  localparam int SEQ_W   = 8;
  localparam int STS_W   = 3;
  localparam int SLOT_W  = 5;
  localparam int DELAY_W = 24;
  localparam int ENTRY_W = NODE_W + EP_W + SEQ_W;

  // Special values
  localparam logic [NODE_W-1:0]  NODE_GATEWAY = 16'h0000;
  localparam logic [NODE_W-1:0]  NODE_UNKNOWN = 16'hFFFF;
  localparam logic [SEQ_W-1:0]   SEQ_UNKNOWN  = 8'hFF;
  localparam logic [DELAY_W-1:0] DELAY_RESET  = 24'd1000;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  // Result status codes
  localparam logic [STS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STS_W-1:0] ST_MISS     = 3'd1;
  localparam logic [STS_W-1:0] ST_IGNORED  = 3'd2;
  localparam logic [STS_W-1:0] ST_UPDATED  = 3'd3;
  localparam logic [STS_W-1:0] ST_APPENDED = 3'd4;
  localparam logic [STS_W-1:0] ST_EVICTED  = 3'd5;
  localparam logic [STS_W-1:0] ST_IDLE     = 3'd6;
  localparam logic [STS_W-1:0] ST_CLEARED  = 3'd7;

  // Which result the datapath forms
  typedef enum logic [2:0] {
    RES_LOOKUP,
    RES_ADD,
    RES_IGNORED,
    RES_TICK,
    RES_NONE
  } res_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     capture;
    logic     scan_start;
    logic     commit_add;
    logic     timer_restart;
    logic     timer_tick;
    logic     res_load;
    res_sel_t res_sel;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             add_gateway;
    logic             add_unknown;
    logic             scan_done;
    logic             out_free;
  } ctl_sts_t;

endpackage

// ----- rtl/sequence_dedup_table.sv -----
// ----------------------------------------------------------------------------
// sequence_dedup_table
// Duplicate suppression table of recent sequence numbers keyed by sender
// node and endpoint, with lookup, add/evict and a tick-driven clear timer.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake             Payload
//  in_      in_valid / in_stall   in_cmd, in_node_id, in_endpoint, in_seq_in
//  out_     out_valid / out_stall out_status, out_seq_out, out_slot
//  cfg_     cfg_valid / cfg_ready cfg_clear_delay_ticks
//
//  Lookups and non-ignored adds walk the whole table: the table memory
//  has one read port and the walk reads one entry a cycle. Ticks, ignored adds
//  and unused commands skip the walk. One transaction is in work at a time.
//  Reset is synchronous; table contents are qualified by valid bits that reset
//  clears at once, so there is no clearing pass.
//  A stalled result waits in the output register while the next transaction
//  is taken; that one completes once the register is free.
//
module sequence_dedup_table #(
  parameter int TABLE_DEPTH = sdt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sdt_pkg::CMD_W-1:0]   in_cmd,
  input  logic [sdt_pkg::NODE_W-1:0]  in_node_id,
  input  logic [sdt_pkg::EP_W-1:0]    in_endpoint,
  input  logic [sdt_pkg::SEQ_W-1:0]   in_seq_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sdt_pkg::STS_W-1:0]   out_status,
  output logic [sdt_pkg::SEQ_W-1:0]   out_seq_out,
  output logic [sdt_pkg::SLOT_W-1:0]  out_slot,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sdt_pkg::DELAY_W-1:0] cfg_clear_delay_ticks
);

  sdt_pkg::ctl_cmd_t cmd;
  sdt_pkg::ctl_sts_t sts;

  // Register write always accepted
  assign cfg_ready = 1'b1;

  sdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sdt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_cmd      (in_cmd),
    .in_node_id  (in_node_id),
    .in_endpoint (in_endpoint),
    .in_seq_in   (in_seq_in),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_wdata   (cfg_clear_delay_ticks),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_seq_out (out_seq_out),
    .out_slot    (out_slot)
  );

endmodule

// ----- rtl/sdt_ram.sv -----
// ----------------------------------------------------------------------------
// sdt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sdt_ram #(
  parameter int WIDTH = sdt_pkg::ENTRY_W,
  parameter int DEPTH = sdt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/sdt_ctrl.sv -----
// ----------------------------------------------------------------------------
// sdt_ctrl
// Sequencer: takes one transaction, starts the table walk where needed and
// commits the result once the output register is free.
// ----------------------------------------------------------------------------
module sdt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sdt_pkg::ctl_sts_t sts,
  output sdt_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt         = state_r;
    cmd               = '0;
    cmd.res_sel       = sdt_pkg::RES_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op) inside
          sdt_pkg::CMD_LOOKUP: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
          sdt_pkg::CMD_ADD: begin
            if (sts.add_gateway || sts.add_unknown) begin
              state_nxt = S_RESULT;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          default: state_nxt = S_RESULT;
        endcase
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
          case (sts.op) inside
            sdt_pkg::CMD_LOOKUP: cmd.res_sel = sdt_pkg::RES_LOOKUP;
            sdt_pkg::CMD_ADD: begin
              if (sts.add_gateway) begin
                cmd.res_sel = sdt_pkg::RES_IGNORED;
              end else if (sts.add_unknown) begin
                cmd.res_sel       = sdt_pkg::RES_IGNORED;
                cmd.timer_restart = 1'b1;
              end else begin
                cmd.res_sel       = sdt_pkg::RES_ADD;
                cmd.commit_add    = 1'b1;
                cmd.timer_restart = 1'b1;
              end
            end
            sdt_pkg::CMD_TICK: begin
              cmd.res_sel    = sdt_pkg::RES_TICK;
              cmd.timer_tick = 1'b1;
            end
            default: cmd.res_sel = sdt_pkg::RES_NONE;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Result only committed into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> sts.out_free)
    else $error("result loaded while output register busy");

  // Walk completion only expected while waiting on it
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    sts.scan_done |-> state_r == S_SCAN)
    else $error("walk finished outside scan state");

  // A walk leads only to the result state
  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |=> state_r == S_SCAN || state_r == S_RESULT)
    else $error("scan state left for wrong state");

endmodule

// ----- rtl/sdt_dpath.sv -----
// ----------------------------------------------------------------------------
// sdt_dpath
// Datapath: transaction capture, table memory with valid bits, table walk
// for first match and oldest entry, fill count, clear timer and the output
// register.
// ----------------------------------------------------------------------------
module sdt_dpath #(
  parameter int TABLE_DEPTH = sdt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sdt_pkg::ctl_cmd_t           cmd,
  output sdt_pkg::ctl_sts_t           sts,
  input  logic [sdt_pkg::CMD_W-1:0]   in_cmd,
  input  logic [sdt_pkg::NODE_W-1:0]  in_node_id,
  input  logic [sdt_pkg::EP_W-1:0]    in_endpoint,
  input  logic [sdt_pkg::SEQ_W-1:0]   in_seq_in,
  input  logic                        cfg_we,
  input  logic [sdt_pkg::DELAY_W-1:0] cfg_wdata,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [sdt_pkg::STS_W-1:0]   out_status,
  output logic [sdt_pkg::SEQ_W-1:0]   out_seq_out,
  output logic [sdt_pkg::SLOT_W-1:0]  out_slot
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = sdt_pkg::ENTRY_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

  function automatic logic [sdt_pkg::SLOT_W-1:0] to_slot(input logic [IW-1:0] idx);
    logic [IW+sdt_pkg::SLOT_W-1:0] w;
    w = {{sdt_pkg::SLOT_W{1'b0}}, idx};
    return w[sdt_pkg::SLOT_W-1:0];
  endfunction

  // Captured transaction
  logic [sdt_pkg::CMD_W-1:0]  op_r;
  logic [sdt_pkg::NODE_W-1:0] node_r;
  logic [sdt_pkg::EP_W-1:0]   ep_r;
  logic [sdt_pkg::SEQ_W-1:0]  seq_r;

  // Table state
  logic [TABLE_DEPTH-1:0]       valid_r;
  logic [CW-1:0]                fill_r;
  logic [sdt_pkg::DELAY_W-1:0]  delay_r;
  logic [sdt_pkg::DELAY_W-1:0]  timer_r;
  logic                         armed_r;

  // Walk state
  logic          run_r;
  logic [IW-1:0] iss_idx_r;
  logic          dvld_r;
  logic [IW-1:0] didx_r;
  logic          done_r;
  logic          found_r;
  logic [IW-1:0] match_idx_r;
  logic [sdt_pkg::SEQ_W-1:0] match_seq_r;
  logic          best_found_r;
  logic [IW-1:0] best_idx_r;
  logic [sdt_pkg::SEQ_W-1:0] best_seq_r;

  // Output register
  logic                       out_valid_r;
  logic [sdt_pkg::STS_W-1:0]  out_status_r;
  logic [sdt_pkg::SEQ_W-1:0]  out_seq_r;
  logic [sdt_pkg::SLOT_W-1:0] out_slot_r;

  logic [EW-1:0]              ram_rdata;
  logic [EW-1:0]              ent;
  logic [sdt_pkg::NODE_W-1:0] e_node;
  logic [sdt_pkg::EP_W-1:0]   e_ep;
  logic [sdt_pkg::SEQ_W-1:0]  e_seq;
  logic                       hit;
  logic                       full;
  logic                       tick_clear;
  logic [IW-1:0]              wr_idx;
  logic [sdt_pkg::STS_W-1:0]  add_st;

  // Table memory
  sdt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.commit_add),
    .waddr (wr_idx),
    .wdata ({node_r, ep_r, seq_r}),
    .raddr (iss_idx_r),
    .rdata (ram_rdata)
  );

  // Entry as read: a slot never written since the last clear reads all ones
  assign ent    = valid_r[didx_r] ? ram_rdata : '1;
  assign e_node = ent[EW-1 -: sdt_pkg::NODE_W];
  assign e_ep   = ent[sdt_pkg::EP_W+sdt_pkg::SEQ_W-1 -: sdt_pkg::EP_W];
  assign e_seq  = ent[sdt_pkg::SEQ_W-1:0];

  // Decisions from the walk and the timer
  assign hit        = found_r && (match_seq_r != sdt_pkg::SEQ_UNKNOWN);
  assign full       = (fill_r >= FULL_CNT);
  assign tick_clear = armed_r && (timer_r <= sdt_pkg::DELAY_W'(1));

  always_comb begin
    if (hit) begin
      wr_idx = match_idx_r;
      add_st = sdt_pkg::ST_UPDATED;
    end else if (full) begin
      wr_idx = best_idx_r;
      add_st = sdt_pkg::ST_EVICTED;
    end else begin
      wr_idx = fill_r[IW-1:0];
      add_st = sdt_pkg::ST_APPENDED;
    end
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_cmd;
      node_r <= in_node_id;
      ep_r   <= in_endpoint;
      seq_r  <= in_seq_in;
    end
  end

  // Walk control: issue one read a cycle, flag the last returned entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= 1'b0;
      dvld_r    <= 1'b0;
      done_r    <= 1'b0;
      iss_idx_r <= '0;
    end else begin
      dvld_r <= run_r;
      done_r <= dvld_r && (didx_r == LAST_IDX);
      if (cmd.scan_start) begin
        run_r     <= 1'b1;
        iss_idx_r <= '0;
      end else if (run_r) begin
        iss_idx_r <= iss_idx_r + IW'(1);
        if (iss_idx_r == LAST_IDX) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  // Walk results: first match, and smallest known sequence (lowest slot on tie)
  always_ff @(posedge clk) begin
    didx_r <= iss_idx_r;
    if (cmd.scan_start) begin
      found_r      <= 1'b0;
      best_found_r <= 1'b0;
      best_idx_r   <= '0;
    end else if (dvld_r) begin
      if (!found_r && e_node == node_r && e_ep == ep_r) begin
        found_r     <= 1'b1;
        match_idx_r <= didx_r;
        match_seq_r <= e_seq;
      end
      if (e_seq != sdt_pkg::SEQ_UNKNOWN && (!best_found_r || e_seq < best_seq_r)) begin
        best_found_r <= 1'b1;
        best_idx_r   <= didx_r;
        best_seq_r   <= e_seq;
      end
    end
  end

  // Configuration, valid bits, fill count and clear timer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= sdt_pkg::DELAY_RESET;
      valid_r <= '0;
      fill_r  <= '0;
      timer_r <= '0;
      armed_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        delay_r <= cfg_wdata;
      end
      if (cmd.commit_add) begin
        valid_r[wr_idx] <= 1'b1;
        if (!hit && !full) begin
          fill_r <= fill_r + CW'(1);
        end
      end
      if (cmd.timer_restart) begin
        timer_r <= delay_r;
        armed_r <= 1'b1;
      end
      if (cmd.timer_tick && armed_r) begin
        if (tick_clear) begin
          valid_r <= '0;
          fill_r  <= '0;
          timer_r <= '0;
          armed_r <= 1'b0;
        end else begin
          timer_r <= timer_r - sdt_pkg::DELAY_W'(1);
        end
      end
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_seq_r  <= sdt_pkg::SEQ_UNKNOWN;
      out_slot_r <= '0;
      case (cmd.res_sel)
        sdt_pkg::RES_LOOKUP: begin
          if (hit) begin
            out_status_r <= sdt_pkg::ST_HIT;
            out_seq_r    <= match_seq_r;
            out_slot_r   <= to_slot(match_idx_r);
          end else begin
            out_status_r <= sdt_pkg::ST_MISS;
          end
        end
        sdt_pkg::RES_ADD: begin
          out_status_r <= add_st;
          out_slot_r   <= to_slot(wr_idx);
        end
        sdt_pkg::RES_IGNORED: out_status_r <= sdt_pkg::ST_IGNORED;
        sdt_pkg::RES_TICK: begin
          out_status_r <= tick_clear ? sdt_pkg::ST_CLEARED : sdt_pkg::ST_IDLE;
        end
        default: out_status_r <= sdt_pkg::ST_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_seq_out = out_seq_r;
  assign out_slot    = out_slot_r;

  // Status towards the controller
  assign sts.op          = op_r;
  assign sts.add_gateway = (node_r == sdt_pkg::NODE_GATEWAY);
  assign sts.add_unknown = (node_r == sdt_pkg::NODE_UNKNOWN) ||
                           (seq_r == sdt_pkg::SEQ_UNKNOWN);
  assign sts.scan_done   = done_r;
  assign sts.out_free    = !out_valid_r || !out_stall;

  // Fill count never passes the table size
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count beyond table size");

  // Valid bits track the fill count exactly
  a_fill_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(fill_r))
    else $error("valid bits disagree with fill count");

  // A disarmed timer holds zero
  a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> timer_r == '0)
    else $error("disarmed timer not zero");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sequence_dedup_table. A model of the table, its
// fill count and its clear timer runs alongside the block. It predicts one
// answer per accepted transaction, and each answer is checked field by field
// as it leaves the block. Directed checks of the special cases and of the
// clear timer come first. A pressure run and randomised phases over several
// clear delays follow, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH = sdt_pkg::TABLE_DEPTH_DEF;
  localparam logic [sdt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = DEPTH + 10;
  localparam int POOL_MAX = 64;

  typedef struct packed {
    logic [sdt_pkg::STS_W-1:0]  status;
    logic [sdt_pkg::SEQ_W-1:0]  seq_out;
    logic [sdt_pkg::SLOT_W-1:0] slot;
  } table_answer_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [sdt_pkg::CMD_W-1:0]    in_cmd = '0;
  logic [sdt_pkg::NODE_W-1:0]   in_node_id = '0;
  logic [sdt_pkg::EP_W-1:0]     in_endpoint = '0;
  logic [sdt_pkg::SEQ_W-1:0]    in_seq_in = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [sdt_pkg::STS_W-1:0]    out_status;
  logic [sdt_pkg::SEQ_W-1:0]    out_seq_out;
  logic [sdt_pkg::SLOT_W-1:0]   out_slot;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [sdt_pkg::DELAY_W-1:0]  cfg_clear_delay_ticks = '0;

  // Model of the table and its clear timer
  logic [sdt_pkg::NODE_W-1:0]   tbl_node [DEPTH];
  logic [sdt_pkg::EP_W-1:0]     tbl_ep [DEPTH];
  logic [sdt_pkg::SEQ_W-1:0]    tbl_seq [DEPTH];
  int unsigned                  tbl_fill;
  logic [sdt_pkg::DELAY_W-1:0]  clear_delay;
  logic [sdt_pkg::DELAY_W-1:0]  clear_left;
  bit                           clear_armed;

  table_answer_t                table_answers [$];
  int                           mismatch_count = 0;

  // Sender pacing
  int                           burst_max = 0;
  int                           gap_max = 0;
  int                           burst_left = 0;

  // Receiver pacing
  int                           stall_pct = 0;
  int                           hold_req = 0;
  int                           hold_cnt = 0;

  // Keys used by the random phases
  logic [sdt_pkg::NODE_W-1:0]   pool_node [POOL_MAX];
  logic [sdt_pkg::EP_W-1:0]     pool_ep [POOL_MAX];

  sequence_dedup_table dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_cmd                (in_cmd),
    .in_node_id            (in_node_id),
    .in_endpoint           (in_endpoint),
    .in_seq_in             (in_seq_in),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_seq_out           (out_seq_out),
    .out_slot              (out_slot),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_clear_delay_ticks (cfg_clear_delay_ticks)
  );

  always #10 clk = ~clk;

  // Random field values at the field widths
  function automatic logic [sdt_pkg::NODE_W-1:0] rand_node();
    return sdt_pkg::NODE_W'($urandom);
  endfunction

  function automatic logic [sdt_pkg::EP_W-1:0] rand_ep();
    return sdt_pkg::EP_W'($urandom);
  endfunction

  function automatic logic [sdt_pkg::SEQ_W-1:0] rand_seq();
    return sdt_pkg::SEQ_W'($urandom);
  endfunction

  // Set every slot to all ones and empty the table
  function automatic void wipe_model();
    int k;
    for (k = 0; k < DEPTH; k++) begin
      tbl_node[k] = sdt_pkg::NODE_UNKNOWN;
      tbl_ep[k]   = '1;
      tbl_seq[k]  = sdt_pkg::SEQ_UNKNOWN;
    end
    tbl_fill = 0;
  endfunction

  // Apply one transaction to the model and return the answer it gives
  function automatic table_answer_t compute_table_answer(
      input logic [sdt_pkg::CMD_W-1:0]  cmd,
      input logic [sdt_pkg::NODE_W-1:0] node,
      input logic [sdt_pkg::EP_W-1:0]   ep,
      input logic [sdt_pkg::SEQ_W-1:0]  seq);
    table_answer_t a;
    int k;
    int match;
    int victim;
    bit seen;
    a.status  = sdt_pkg::ST_IDLE;
    a.seq_out = sdt_pkg::SEQ_UNKNOWN;
    a.slot    = '0;
    // first slot whose node and endpoint match, DEPTH when none
    match = DEPTH;
    for (k = DEPTH - 1; k >= 0; k--)
      if (tbl_node[k] == node && tbl_ep[k] == ep) match = k;
    case (cmd)
      sdt_pkg::CMD_LOOKUP: begin
        if (match < DEPTH && tbl_seq[match] != sdt_pkg::SEQ_UNKNOWN) begin
          a.status  = sdt_pkg::ST_HIT;
          a.seq_out = tbl_seq[match];
          a.slot    = sdt_pkg::SLOT_W'(match);
        end else begin
          a.status = sdt_pkg::ST_MISS;
        end
      end
      sdt_pkg::CMD_ADD: begin
        if (node == sdt_pkg::NODE_GATEWAY) begin
          a.status = sdt_pkg::ST_IGNORED;
        end else begin
          if (node == sdt_pkg::NODE_UNKNOWN || seq == sdt_pkg::SEQ_UNKNOWN) begin
            a.status = sdt_pkg::ST_IGNORED;
          end else begin
            if (match < DEPTH && tbl_seq[match] != sdt_pkg::SEQ_UNKNOWN) begin
              k = match;
              a.status = sdt_pkg::ST_UPDATED;
            end else if (tbl_fill >= DEPTH) begin
              // evict the smallest stored sequence, lowest slot on a tie
              victim = 0;
              seen = 1'b0;
              for (k = 0; k < DEPTH; k++)
                if (tbl_seq[k] != sdt_pkg::SEQ_UNKNOWN &&
                    (!seen || tbl_seq[k] < tbl_seq[victim])) begin
                  victim = k;
                  seen = 1'b1;
                end
              k = victim;
              a.status = sdt_pkg::ST_EVICTED;
            end else begin
              k = tbl_fill;
              tbl_fill++;
              a.status = sdt_pkg::ST_APPENDED;
            end
            tbl_node[k] = node;
            tbl_ep[k]   = ep;
            tbl_seq[k]  = seq;
            a.slot      = sdt_pkg::SLOT_W'(k);
          end
          clear_left  = clear_delay;
          clear_armed = 1'b1;
        end
      end
      sdt_pkg::CMD_TICK: begin
        if (clear_armed) begin
          if (clear_left <= sdt_pkg::DELAY_W'(1)) begin
            wipe_model();
            clear_left  = '0;
            clear_armed = 1'b0;
            a.status    = sdt_pkg::ST_CLEARED;
          end else begin
            clear_left = clear_left - sdt_pkg::DELAY_W'(1);
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb_top: mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Compare one result transaction with the oldest awaited answer
  task automatic check_answer();
    table_answer_t want;
    if (table_answers.size() == 0) begin
      report_mismatch("result with nothing awaited, status", 32'(out_status), '0);
    end else begin
      want = table_answers.pop_front();
      if (out_status !== want.status)
        report_mismatch("status", 32'(out_status), 32'(want.status));
      if (out_seq_out !== want.seq_out)
        report_mismatch("seq_out", 32'(out_seq_out), 32'(want.seq_out));
      if (out_slot !== want.slot)
        report_mismatch("slot", 32'(out_slot), 32'(want.slot));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_answer();
  end

  // Receiver: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req > 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_req - 1;
    end else begin
      out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Offer one transaction, hold it until accepted, then pause between bursts
  task automatic send_item(input logic [sdt_pkg::CMD_W-1:0] cmd,
                           input logic [sdt_pkg::NODE_W-1:0] node,
                           input logic [sdt_pkg::EP_W-1:0] ep,
                           input logic [sdt_pkg::SEQ_W-1:0] seq);
    int gap;
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_node_id  <= node;
    in_endpoint <= ep;
    in_seq_in   <= seq;
    do @(posedge clk); while (in_stall);
    table_answers.push_back(compute_table_answer(cmd, node, ep, seq));
    if (gap_max > 0) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(1, gap_max);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(0, burst_max);
      end
    end
  endtask

  // Drop valid and wait until every awaited answer has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (table_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_clear_delay(input logic [sdt_pkg::DELAY_W-1:0] value);
    cfg_valid             <= 1'b1;
    cfg_clear_delay_ticks <= value;
    do @(posedge clk); while (!cfg_ready);
    clear_delay = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_pacing(input int bursts, input int gaps, input int stalls);
    burst_max  = bursts;
    gap_max    = gaps;
    stall_pct  = stalls;
    burst_left = 0;
  endtask

  // Draw a fresh set of keys, avoiding the gateway and unknown node
  task automatic fill_key_pool(input int size);
    int i;
    for (i = 0; i < size; i++) begin
      pool_node[i] = rand_node();
      pool_ep[i]   = rand_ep();
      case ($urandom_range(0, 7))
        0: pool_node[i] = 16'h0001;
        1: pool_node[i] = 16'hFFFE;
        2: pool_ep[i] = 8'h00;
        3: pool_ep[i] = 8'hFF;
        default: ;
      endcase
      if (pool_node[i] == sdt_pkg::NODE_GATEWAY) pool_node[i] = 16'h0001;
      if (pool_node[i] == sdt_pkg::NODE_UNKNOWN) pool_node[i] = 16'hFFFE;
    end
  endtask

  // Special cases, every command and the field extremes
  task automatic test_directed();
    set_pacing(3, 4, 30);
    send_item(sdt_pkg::CMD_LOOKUP, sdt_pkg::NODE_UNKNOWN, 8'hFF, 8'h00);  // match on an empty slot
    send_item(sdt_pkg::CMD_LOOKUP, 16'h1234, 8'h05, 8'h00);
    send_item(sdt_pkg::CMD_TICK, 16'h0000, 8'h00, 8'h00);        // tick while disarmed
    send_item(sdt_pkg::CMD_ADD, sdt_pkg::NODE_GATEWAY, 8'h01, 8'h0A);  // gateway leaves timer
    send_item(sdt_pkg::CMD_TICK, 16'hFFFF, 8'hFF, 8'hFF);
    send_item(sdt_pkg::CMD_ADD, sdt_pkg::NODE_UNKNOWN, 8'h03, 8'h14);  // unknown node arms timer
    send_item(sdt_pkg::CMD_ADD, 16'h0022, 8'h01, sdt_pkg::SEQ_UNKNOWN);  // unknown sequence
    send_item(sdt_pkg::CMD_ADD, 16'h0001, 8'h00, 8'h00);
    send_item(sdt_pkg::CMD_ADD, 16'hFFFE, 8'hFF, 8'hFE);
    send_item(sdt_pkg::CMD_ADD, 16'h8000, 8'h80, 8'h7F);
    send_item(sdt_pkg::CMD_LOOKUP, 16'h0001, 8'h00, 8'hFF);
    send_item(sdt_pkg::CMD_LOOKUP, 16'hFFFE, 8'hFF, 8'h00);
    send_item(sdt_pkg::CMD_ADD, 16'h0001, 8'h00, 8'h80);         // overwrite in place
    send_item(sdt_pkg::CMD_LOOKUP, 16'h0001, 8'h00, 8'h00);
    send_item(sdt_pkg::CMD_LOOKUP, 16'h0001, 8'h01, 8'h00);
    send_item(sdt_pkg::CMD_LOOKUP, sdt_pkg::NODE_UNKNOWN, 8'hFF, 8'hFF);
    send_item(CMD_UNUSED, 16'hFFFF, 8'hFF, 8'hFF);
    send_item(CMD_UNUSED, 16'h0000, 8'h00, 8'h00);
    wait_idle();
  endtask

  // Timer expiry at the shortest delay and restart by a later add
  task automatic test_clear_timer();
    write_clear_delay(sdt_pkg::DELAY_W'(1));
    send_item(sdt_pkg::CMD_ADD, 16'h0005, 8'h05, 8'h05);
    send_item(sdt_pkg::CMD_TICK, 16'h0000, 8'h00, 8'h00);
    send_item(sdt_pkg::CMD_LOOKUP, 16'h0005, 8'h05, 8'h00);
    wait_idle();
    write_clear_delay(sdt_pkg::DELAY_W'(3));
    send_item(sdt_pkg::CMD_ADD, 16'h0006, 8'h06, 8'h06);
    send_item(sdt_pkg::CMD_TICK, 16'h0000, 8'h00, 8'h00);
    send_item(sdt_pkg::CMD_ADD, 16'h0007, 8'h07, 8'h07);
    send_item(sdt_pkg::CMD_TICK, 16'h0000, 8'h00, 8'h00);
    send_item(sdt_pkg::CMD_TICK, 16'h0000, 8'h00, 8'h00);
    send_item(sdt_pkg::CMD_TICK, 16'h0000, 8'h00, 8'h00);
    wait_idle();
  endtask

  // Hold the receiver off while the sender keeps offering transactions
  task automatic test_pressure();
    int i;
    int k;
    write_clear_delay(sdt_pkg::DELAY_W'(1000));
    fill_key_pool(12);
    set_pacing(0, 0, 0);
    hold_req <= 300;
    @(posedge clk);
    hold_req <= 0;
    for (i = 0; i < 24; i++) begin
      k = $urandom_range(0, 11);
      if (i % 3 == 2)
        send_item(sdt_pkg::CMD_LOOKUP, pool_node[k], pool_ep[k], 8'h00);
      else
        send_item(sdt_pkg::CMD_ADD, pool_node[k], pool_ep[k],
                  sdt_pkg::SEQ_W'($urandom_range(0, 254)));
    end
    wait_idle();
  endtask

  // One random phase: mostly adds and lookups on a key pool, tick runs, noise
  task automatic test_random(input int n_items, input logic [sdt_pkg::DELAY_W-1:0] delay,
                             input int pool_size, input int seq_hi, input int tick_pct,
                             input int bursts, input int gaps, input int stalls);
    int count;
    int pick;
    int k;
    int run;
    write_clear_delay(delay);
    fill_key_pool(pool_size);
    set_pacing(bursts, gaps, stalls);
    count = 0;
    while (count < n_items) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, pool_size - 1);
      if (pick < 40) begin
        send_item(sdt_pkg::CMD_ADD, pool_node[k], pool_ep[k],
                  sdt_pkg::SEQ_W'($urandom_range(0, seq_hi)));
        count++;
      end else if (pick < 70) begin
        send_item(sdt_pkg::CMD_LOOKUP, pool_node[k], pool_ep[k], rand_seq());
        count++;
      end else if (pick < 70 + tick_pct) begin
        run = $urandom_range(1, 12);
        repeat (run) send_item(sdt_pkg::CMD_TICK, rand_node(), rand_ep(), rand_seq());
        count += run;
      end else begin
        case ($urandom_range(0, 5))
          0: send_item(sdt_pkg::CMD_ADD, sdt_pkg::NODE_GATEWAY, rand_ep(), rand_seq());
          1: send_item(sdt_pkg::CMD_ADD, sdt_pkg::NODE_UNKNOWN, rand_ep(), rand_seq());
          2: send_item(sdt_pkg::CMD_ADD, pool_node[k], pool_ep[k], sdt_pkg::SEQ_UNKNOWN);
          3: send_item(CMD_UNUSED, rand_node(), rand_ep(), rand_seq());
          4: send_item(sdt_pkg::CMD_LOOKUP, rand_node(), rand_ep(), rand_seq());
          default: send_item(sdt_pkg::CMD_LOOKUP, sdt_pkg::NODE_UNKNOWN, 8'hFF, rand_seq());
        endcase
        count++;
      end
    end
    wait_idle();
  endtask

  initial begin
    wipe_model();
    clear_delay = sdt_pkg::DELAY_RESET;
    clear_left  = '0;
    clear_armed = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_clear_timer();
    test_pressure();
    test_random(180, sdt_pkg::DELAY_W'(24'hFFFFFF), 30, 254, 10, 4, 6, 30);
    test_random(150, sdt_pkg::DELAY_W'(1), 8, 254, 20, 0, 0, 0);
    test_random(180, sdt_pkg::DELAY_W'(5), 40, 3, 15, 2, 30, 50);
    test_random(160, sdt_pkg::DELAY_W'(1000), 24, 254, 10, 6, 3, 70);
    test_random(180, sdt_pkg::DELAY_W'($urandom_range(2, 12)), 64, 254, 15, 3, 10, 20);
    test_random(150, sdt_pkg::DELAY_W'(2), 21, 15, 20, 5, 2, 10);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #10_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sdt_pkg.sv
rtl/sdt_ram.sv
rtl/sdt_ctrl.sv
rtl/sdt_dpath.sv
rtl/sequence_dedup_table.sv
test/tb_top.sv
